/* rtl/core/vna_pkg.sv */
package vna_pkg;

    // fixed field widths
    localparam int IDX_W     = 10;
    localparam int POS_W     = 16;
    localparam int NRM_W     = 16;
    localparam int EDGE_W    = POS_W + 1;
    localparam int CROSS_W   = 2 * EDGE_W;
    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 64;

    // normalization datapath
    localparam int NORM_BITS = 24;
    localparam int Q_W       = 52;
    localparam int LEN_W     = Q_W / 2;
    localparam int FRAC_BITS = 14;
    localparam int QUO_W     = 15;
    localparam int NUM_W     = NORM_BITS + FRAC_BITS + 1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TRI   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000_0000_0000_0001,
        ST_LOAD   = 16'b0000_0000_0000_0010,
        ST_TRD    = 16'b0000_0000_0000_0100,
        ST_TEDGE  = 16'b0000_0000_0000_1000,
        ST_TCROSS = 16'b0000_0000_0001_0000,
        ST_SRD    = 16'b0000_0000_0010_0000,
        ST_SWR    = 16'b0000_0000_0100_0000,
        ST_QRD    = 16'b0000_0000_1000_0000,
        ST_QMAG   = 16'b0000_0001_0000_0000,
        ST_QLZ    = 16'b0000_0010_0000_0000,
        ST_QSCALE = 16'b0000_0100_0000_0000,
        ST_QSQ    = 16'b0000_1000_0000_0000,
        ST_QSQRT  = 16'b0001_0000_0000_0000,
        ST_QDINIT = 16'b0010_0000_0000_0000,
        ST_QDIV   = 16'b0100_0000_0000_0000,
        ST_OUT    = 16'b1000_0000_0000_0000
    } state_t;

    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [CROSS_W-1:0] cross_t;

endpackage

/* rtl/core/vertex_normal_accumulator_unit.sv */
// Area-weighted vertex normal accumulator. Load transactions store a vertex
// position and clear its normal sum; triangle transactions add the edge cross
// product to the sums of all three corners with saturation; query
// transactions return the unit normal in signed Q1.14 (zero_sum flags a zero
// sum or an index out of range). Positions and sums live in two single-port
// synchronous memories, and one transaction is worked on at a time. A load
// writes the position and the cleared sum together; a triangle does three
// position reads, three cross product steps, then a read and a write of the
// sum memory per corner. In a query the leading-one search steps one bit a
// cycle, the square root retires one bit a cycle of a 26-bit result and the
// divider takes a setup step plus one quotient bit a cycle of a 15-bit
// quotient for each of the three components. A finished result waits in the
// output register while the next transaction is accepted. No clearing pass
// runs after reset.
module vertex_normal_accumulator_unit #(
    parameter int VERTEX_COUNT = 1024,
    parameter int SUM_WIDTH    = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // index_a, index_b, index_c, pos_x, pos_y, pos_z, zero pad
    input  logic [vna_pkg::IN_DATA_W-1:0]        s_tdata,
    // kind
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // vertex_index, normal_x, normal_y, normal_z, zero pad
    output logic [vna_pkg::OUT_DATA_W-1:0]       m_tdata,
    // zero_sum
    output logic [0:0]                           m_tuser
);

    localparam int AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int XW  = (AW > vna_pkg::IDX_W) ? AW : vna_pkg::IDX_W;
    localparam int W   = SUM_WIDTH;
    localparam int BLW = $clog2(SUM_WIDTH + 1);
    localparam int PW  = 3 * vna_pkg::POS_W;
    localparam logic [BLW-1:0] NORM_BL = BLW'(vna_pkg::NORM_BITS);

    // input fields
    vna_pkg::kind_t               in_kind;
    logic [vna_pkg::IDX_W-1:0]    in_idx [3];
    logic [PW-1:0]                in_pos;
    logic                         in_a_ok;
    logic                         in_all_ok;

    assign in_kind   = vna_pkg::kind_t'(s_tuser);
    assign in_idx[0] = s_tdata[9:0];
    assign in_idx[1] = s_tdata[19:10];
    assign in_idx[2] = s_tdata[29:20];
    assign in_pos    = s_tdata[77:30];
    assign in_a_ok   = 32'(in_idx[0]) < 32'(VERTEX_COUNT);
    assign in_all_ok = in_a_ok && (32'(in_idx[1]) < 32'(VERTEX_COUNT))
                       && (32'(in_idx[2]) < 32'(VERTEX_COUNT));

    // registers
    vna_pkg::state_t              state_reg, state_next;
    logic [vna_pkg::IDX_W-1:0]    idx_reg [3], idx_next [3];
    logic [PW-1:0]                pos_reg, pos_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic [4:0]                   step_reg, step_next;
    logic [PW-1:0]                pa_reg, pa_next, pb_reg, pb_next;
    vna_pkg::edge_t               e1_reg [3], e1_next [3], e2_reg [3], e2_next [3];
    vna_pkg::cross_t              cross_reg [3], cross_next [3];
    logic [W-1:0]                 m_reg [3], m_next [3];
    logic                         sgn_reg [3], sgn_next [3];
    logic [W-1:0]                 mx_reg, mx_next;
    logic [BLW-1:0]               bl_reg, bl_next;
    logic [vna_pkg::NORM_BITS-1:0] a_reg [3], a_next [3];
    logic [vna_pkg::Q_W-1:0]      q_reg, q_next, res_reg, res_next, bit_reg, bit_next;
    logic [vna_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [vna_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [vna_pkg::LEN_W:0]      rem_reg, rem_next;
    logic [vna_pkg::QUO_W-1:0]    quo_reg, quo_next;
    logic [vna_pkg::NRM_W-1:0]    n_reg [3], n_next [3];
    logic                         zero_reg, zero_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [vna_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                         out_flag_reg, out_flag_next;

    // memories
    logic [PW-1:0]                pos_mem [VERTEX_COUNT];
    logic [PW-1:0]                pos_rdata_reg;
    logic [3*W-1:0]               sum_mem [VERTEX_COUNT];
    logic [3*W-1:0]               sum_rdata_reg;
    logic                         pos_we, sum_we;
    logic [PW-1:0]                pos_wdata;
    logic [3*W-1:0]               sum_wdata;
    logic [XW-1:0]                addr_ext;
    logic [AW-1:0]                mem_addr;

    assign addr_ext = XW'(idx_reg[cnt_reg]);
    assign mem_addr = addr_ext[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[mem_addr] <= pos_wdata;
        end
        pos_rdata_reg <= pos_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[mem_addr] <= sum_wdata;
        end
        sum_rdata_reg <= sum_mem[mem_addr];
    end

    // cross product operand selection, one component per cycle
    vna_pkg::edge_t               xp, xq, xr, xs;
    logic signed [vna_pkg::CROSS_W:0] cross_full;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:
            begin
                xp = e1_reg[1]; xq = e2_reg[2]; xr = e1_reg[2]; xs = e2_reg[1];
            end
            2'd1:
            begin
                xp = e1_reg[2]; xq = e2_reg[0]; xr = e1_reg[0]; xs = e2_reg[2];
            end
            default:
            begin
                xp = e1_reg[0]; xq = e2_reg[1]; xr = e1_reg[1]; xs = e2_reg[0];
            end
        endcase
        cross_full = (vna_pkg::CROSS_W+1)'(xp * xq) - (vna_pkg::CROSS_W+1)'(xr * xs);
    end

    // saturating accumulate of the three lanes
    logic [3*W-1:0]               sat_sum;
    logic signed [W:0]            lane_sum [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lane_sum[i] = (W+1)'(signed'(sum_rdata_reg[i*W +: W]))
                          + (W+1)'(cross_reg[i]);
            if (lane_sum[i][W] != lane_sum[i][W-1])
            begin
                sat_sum[i*W +: W] = lane_sum[i][W] ? {1'b1, {(W-1){1'b0}}}
                                                    : {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                sat_sum[i*W +: W] = lane_sum[i][W-1:0];
            end
        end
    end

    // magnitudes of the read sum
    logic [W-1:0]                 mag [3];
    logic [W-1:0]                 mag_max01;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = sum_rdata_reg[i*W + W-1] ? (W'(0) - sum_rdata_reg[i*W +: W])
                                               : sum_rdata_reg[i*W +: W];
        end
        mag_max01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
    end

    // square root step and divider step
    logic [vna_pkg::Q_W-1:0]      sq_trial;
    logic [vna_pkg::LEN_W:0]      div_trial;
    logic                         div_ge;
    logic [2*vna_pkg::NORM_BITS-1:0] sq_prod;

    assign sq_trial  = res_reg + bit_reg;
    assign div_trial = {rem_reg[vna_pkg::LEN_W-1:0], num_reg[vna_pkg::NUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, len_reg};
    assign sq_prod   = a_reg[cnt_reg] * a_reg[cnt_reg];

    // sequencer and datapath next state
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        e1_next       = e1_reg;
        e2_next       = e2_reg;
        cross_next    = cross_reg;
        m_next        = m_reg;
        sgn_next      = sgn_reg;
        mx_next       = mx_reg;
        bl_next       = bl_reg;
        a_next        = a_reg;
        q_next        = q_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        len_next      = len_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        n_next        = n_reg;
        zero_next     = zero_reg;
        m_tvalid_next = m_tvalid_reg;
        out_data_next = out_data_reg;
        out_flag_next = out_flag_reg;
        pos_we        = 1'b0;
        sum_we        = 1'b0;
        pos_wdata     = pos_reg;
        sum_wdata     = sat_sum;

        // output register drains independently
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            vna_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next = in_idx;
                    pos_next = in_pos;
                    cnt_next = 2'd0;
                    unique case (in_kind)
                        vna_pkg::KIND_LOAD:
                        begin
                            if (in_a_ok)
                            begin
                                state_next = vna_pkg::ST_LOAD;
                            end
                        end
                        vna_pkg::KIND_TRI:
                        begin
                            if (in_all_ok)
                            begin
                                state_next = vna_pkg::ST_TRD;
                            end
                        end
                        vna_pkg::KIND_QUERY:
                        begin
                            if (in_a_ok)
                            begin
                                state_next = vna_pkg::ST_QRD;
                            end
                            else
                            begin
                                zero_next  = 1'b1;
                                n_next     = '{default: '0};
                                state_next = vna_pkg::ST_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = vna_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            vna_pkg::ST_LOAD:
            begin
                pos_we     = 1'b1;
                sum_we     = 1'b1;
                sum_wdata  = '0;
                state_next = vna_pkg::ST_IDLE;
            end

            // read corners a, b, c; data returns in the following cycle
            vna_pkg::ST_TRD:
            begin
                if (cnt_reg == 2'd1)
                begin
                    pa_next = pos_rdata_reg;
                end
                if (cnt_reg == 2'd2)
                begin
                    pb_next    = pos_rdata_reg;
                    state_next = vna_pkg::ST_TEDGE;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end

            vna_pkg::ST_TEDGE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_next[i] = vna_pkg::EDGE_W'(signed'(pb_reg[i*16 +: 16]))
                                 - vna_pkg::EDGE_W'(signed'(pa_reg[i*16 +: 16]));
                    e2_next[i] = vna_pkg::EDGE_W'(signed'(pos_rdata_reg[i*16 +: 16]))
                                 - vna_pkg::EDGE_W'(signed'(pa_reg[i*16 +: 16]));
                end
                cnt_next   = 2'd0;
                state_next = vna_pkg::ST_TCROSS;
            end

            vna_pkg::ST_TCROSS:
            begin
                cross_next[cnt_reg] = cross_full[vna_pkg::CROSS_W-1:0];
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = 2'd0;
                    state_next = vna_pkg::ST_SRD;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end

            // read then write each corner; no overlap, so repeated corners chain
            vna_pkg::ST_SRD:
            begin
                state_next = vna_pkg::ST_SWR;
            end

            vna_pkg::ST_SWR:
            begin
                sum_we = 1'b1;
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = 2'd0;
                    state_next = vna_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = vna_pkg::ST_SRD;
                end
            end

            vna_pkg::ST_QRD:
            begin
                state_next = vna_pkg::ST_QMAG;
            end

            vna_pkg::ST_QMAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_next[i]   = mag[i];
                    sgn_next[i] = sum_rdata_reg[i*W + W-1];
                end
                mx_next    = (mag[2] > mag_max01) ? mag[2] : mag_max01;
                bl_next    = BLW'(W);
                state_next = vna_pkg::ST_QLZ;
            end

            // leading-one search, one bit a cycle
            vna_pkg::ST_QLZ:
            begin
                if (mx_reg == '0)
                begin
                    zero_next  = 1'b1;
                    n_next     = '{default: '0};
                    state_next = vna_pkg::ST_OUT;
                end
                else if (mx_reg[W-1])
                begin
                    state_next = vna_pkg::ST_QSCALE;
                end
                else
                begin
                    mx_next = {mx_reg[W-2:0], 1'b0};
                    bl_next = bl_reg - BLW'(1);
                end
            end

            vna_pkg::ST_QSCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (bl_reg > NORM_BL)
                    begin
                        a_next[i] = vna_pkg::NORM_BITS'(m_reg[i] >> (bl_reg - NORM_BL));
                    end
                    else
                    begin
                        a_next[i] = vna_pkg::NORM_BITS'(m_reg[i] << (NORM_BL - bl_reg));
                    end
                end
                q_next     = '0;
                cnt_next   = 2'd0;
                state_next = vna_pkg::ST_QSQ;
            end

            vna_pkg::ST_QSQ:
            begin
                q_next = q_reg + vna_pkg::Q_W'(sq_prod);
                if (cnt_reg == 2'd2)
                begin
                    res_next   = '0;
                    bit_next   = vna_pkg::Q_W'(1) << (vna_pkg::Q_W - 2);
                    step_next  = '0;
                    state_next = vna_pkg::ST_QSQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end

            // digit-by-digit square root
            vna_pkg::ST_QSQRT:
            begin
                if (q_reg >= sq_trial)
                begin
                    q_next   = q_reg - sq_trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(vna_pkg::LEN_W - 1))
                begin
                    len_next   = res_next[vna_pkg::LEN_W-1:0];
                    cnt_next   = 2'd0;
                    state_next = vna_pkg::ST_QDINIT;
                end
            end

            vna_pkg::ST_QDINIT:
            begin
                num_next = (vna_pkg::NUM_W'(a_reg[cnt_reg]) << vna_pkg::FRAC_BITS)
                           + vna_pkg::NUM_W'(len_reg >> 1);
                rem_next   = (vna_pkg::LEN_W+1)'(num_next[vna_pkg::NUM_W-1:vna_pkg::QUO_W]);
                num_next   = num_next << (vna_pkg::NUM_W - vna_pkg::QUO_W);
                step_next  = '0;
                state_next = vna_pkg::ST_QDIV;
            end

            // restoring divider, one quotient bit a cycle
            vna_pkg::ST_QDIV:
            begin
                rem_next  = div_ge ? (div_trial - {1'b0, len_reg}) : div_trial;
                quo_next  = {quo_reg[vna_pkg::QUO_W-2:0], div_ge};
                num_next  = num_reg << 1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(vna_pkg::QUO_W - 1))
                begin
                    n_next[cnt_reg] = sgn_reg[cnt_reg]
                        ? (vna_pkg::NRM_W'(0) - vna_pkg::NRM_W'(quo_next))
                        : vna_pkg::NRM_W'(quo_next);
                    if (cnt_reg == 2'd2)
                    begin
                        zero_next  = 1'b0;
                        state_next = vna_pkg::ST_OUT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 2'd1;
                        state_next = vna_pkg::ST_QDINIT;
                    end
                end
            end

            vna_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {6'b0, n_reg[2], n_reg[1], n_reg[0], idx_reg[0]};
                    out_flag_next = zero_reg;
                    state_next    = vna_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vna_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vna_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            step_reg     <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        e1_reg       <= e1_next;
        e2_reg       <= e2_next;
        cross_reg    <= cross_next;
        m_reg        <= m_next;
        sgn_reg      <= sgn_next;
        mx_reg       <= mx_next;
        bl_reg       <= bl_next;
        a_reg        <= a_next;
        q_reg        <= q_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        len_reg      <= len_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        n_reg        <= n_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    assign s_tready = (state_reg == vna_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

    // checks
    a_sum_we_src: assert property (@(posedge clk) disable iff (!rst_n)
        sum_we |-> (state_reg == vna_pkg::ST_SWR || state_reg == vna_pkg::ST_LOAD))
        else $error("sum memory written outside load or accumulate");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vna_pkg::ST_QDIV) |-> (rem_reg < {1'b0, len_reg}))
        else $error("divider remainder not below divisor");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vna_pkg::ST_QDINIT) |-> (len_reg != '0))
        else $error("zero length reached the divider");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vna_pkg::ST_OUT && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("result not presented after completion");

endmodule

/* bench/vna_checker.sv */
`timescale 1ns / 1ps

module vna_checker
(
    input  logic        clk,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          mismatches,
    output int          pending
);

    localparam longint SUM_HI = (64'sd1 <<< 47) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct {
        logic [9:0]         vtx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               zs;
    } normal_rec_t;

    // shadow copy of the vertex stores
    logic signed [15:0] px [1024];
    logic signed [15:0] py [1024];
    logic signed [15:0] pz [1024];
    longint             sum_x [1024];
    longint             sum_y [1024];
    longint             sum_z [1024];

    normal_rec_t normal_q [$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
        for (int i = 0; i < 1024; i++)
        begin
            px[i] = '0; py[i] = '0; pz[i] = '0;
            sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
        end
    end

    function automatic longint sat_sum(input longint acc, input longint inc);
        if (inc > 0 && acc > SUM_HI - inc)
            return SUM_HI;
        if (inc < 0 && acc < SUM_LO - inc)
            return SUM_LO;
        return acc + inc;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned q);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > q)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (q >= res + bitv)
            begin
                q   = q - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // update the shadow state for one accepted transaction
    task automatic accumulate_item(input logic [1:0] k, input logic [79:0] d);
        logic [9:0]      a;
        logic [9:0]      b;
        logic [9:0]      c;
        logic [9:0]      corner [3];
        longint          e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        longint          s [3];
        longint unsigned m [3];
        longint unsigned mx, q, len;
        longint          comp;
        int              bl;
        normal_rec_t     rec;
        a = d[9:0];
        b = d[19:10];
        c = d[29:20];
        case (vna_pkg::kind_t'(k))
            vna_pkg::KIND_LOAD:
            begin
                px[a] = d[45:30];
                py[a] = d[61:46];
                pz[a] = d[77:62];
                sum_x[a] = 0; sum_y[a] = 0; sum_z[a] = 0;
            end
            vna_pkg::KIND_TRI:
            begin
                e1x = longint'(px[b]) - longint'(px[a]);
                e1y = longint'(py[b]) - longint'(py[a]);
                e1z = longint'(pz[b]) - longint'(pz[a]);
                e2x = longint'(px[c]) - longint'(px[a]);
                e2y = longint'(py[c]) - longint'(py[a]);
                e2z = longint'(pz[c]) - longint'(pz[a]);
                nx = e1y * e2z - e1z * e2y;
                ny = e1z * e2x - e1x * e2z;
                nz = e1x * e2y - e1y * e2x;
                corner[0] = a; corner[1] = b; corner[2] = c;
                for (int i = 0; i < 3; i++)
                begin
                    sum_x[corner[i]] = sat_sum(sum_x[corner[i]], nx);
                    sum_y[corner[i]] = sat_sum(sum_y[corner[i]], ny);
                    sum_z[corner[i]] = sat_sum(sum_z[corner[i]], nz);
                end
            end
            vna_pkg::KIND_QUERY:
            begin
                rec.vtx = a;
                rec.nx = '0; rec.ny = '0; rec.nz = '0;
                rec.zs = 1'b1;
                s[0] = sum_x[a]; s[1] = sum_y[a]; s[2] = sum_z[a];
                for (int i = 0; i < 3; i++)
                    m[i] = (s[i] < 0) ? longint'(-s[i]) : s[i];
                mx = m[0];
                if (m[1] > mx) mx = m[1];
                if (m[2] > mx) mx = m[2];
                if (mx != 0)
                begin
                    bl = 0;
                    while (bl < 64 && (mx >> bl) != 0)
                        bl++;
                    // scale the largest magnitude to 24 bits
                    for (int i = 0; i < 3; i++)
                        m[i] = (bl > 24) ? (m[i] >> (bl - 24)) : (m[i] << (24 - bl));
                    q   = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
                    len = int_sqrt(q);
                    for (int i = 0; i < 3; i++)
                    begin
                        comp = longint'((64'd16384 * m[i] + len / 2) / len);
                        if (s[i] < 0)
                            comp = -comp;
                        if (i == 0) rec.nx = comp[15:0];
                        if (i == 1) rec.ny = comp[15:0];
                        if (i == 2) rec.nz = comp[15:0];
                    end
                    rec.zs = 1'b0;
                end
                normal_q = {normal_q, rec};
            end
            default:
            begin
            end
        endcase
    endtask

    // predict on input transactions, compare on output transactions
    always @(posedge clk)
    begin
        normal_rec_t exp_rec;
        if (s_tvalid && s_tready)
            accumulate_item(s_tuser, s_tdata);
        if (m_tvalid && m_tready)
        begin
            if (normal_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected normal result: %h / %b", $realtime,
                             m_tdata, m_tuser);
            end
            else
            begin
                exp_rec = normal_q.pop_front();
                if (m_tdata[9:0] !== exp_rec.vtx || m_tdata[25:10] !== exp_rec.nx ||
                    m_tdata[41:26] !== exp_rec.ny || m_tdata[57:42] !== exp_rec.nz ||
                    m_tuser[0] !== exp_rec.zs)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] normal mismatch: exp vtx=%0d n=(%0d,%0d,%0d) zs=%0b,",
                                 $realtime, exp_rec.vtx, exp_rec.nx, exp_rec.ny,
                                 exp_rec.nz, exp_rec.zs,
                                 " got vtx=%0d n=(%0d,%0d,%0d) zs=%0b", m_tdata[9:0],
                                 $signed(m_tdata[25:10]), $signed(m_tdata[41:26]),
                                 $signed(m_tdata[57:42]), m_tuser[0]);
                end
            end
        end
        pending <= normal_q.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SAT_TRIS    = 8;
    localparam int RAND_ITEMS  = 1300;
    localparam int POOL_N      = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = vna_pkg::KIND_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    int          mismatches;
    int          pending;
    int          items_sent = 0;
    bit          quiet = 1'b0;
    logic [9:0]  pool [POOL_N];

    vertex_normal_accumulator_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    vna_checker chk
    (
        .clk        (clk),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // offer one transaction and hold it until accepted
    task automatic send(input vna_pkg::kind_t k, input logic [9:0] a,
                        input logic [9:0] b, input logic [9:0] c,
                        input logic [15:0] x, input logic [15:0] y,
                        input logic [15:0] z);
        int gap;
        s_tdata  <= {2'b00, z, y, x, c, b, a};
        s_tuser  <= k;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver: random back-pressure plus one long hold-off
    initial
    begin
        bit held_once;
        int gap;
        held_once = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_once && items_sent >= 400)
            begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int          r;
        logic [9:0]  a;
        logic [9:0]  b;
        logic [9:0]  c;
        logic [15:0] ra;
        logic [15:0] rb;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero sums, repeated corners, unused kind, reload
        send(vna_pkg::KIND_LOAD, 10'd0, 10'd0, 10'd0, 16'h0000, 16'h0000, 16'h0000);
        send(vna_pkg::KIND_LOAD, 10'd1023, 10'd0, 10'd0, 16'h7fff, 16'h8000, 16'h5555);
        send(vna_pkg::KIND_LOAD, 10'd682, 10'd0, 10'd0, 16'h8000, 16'h7fff, 16'hffff);
        send(vna_pkg::KIND_LOAD, 10'd341, 10'd0, 10'd0, 16'h0100, 16'h0000, 16'haaaa);
        send(vna_pkg::KIND_QUERY, 10'd0, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_TRI, 10'd0, 10'd1023, 10'd682, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_TRI, 10'd0, 10'd1023, 10'd1023, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_TRI, 10'd682, 10'd682, 10'd341, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_TRI, 10'd341, 10'd0, 10'd682, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_NONE, 10'h3ff, 10'h3ff, 10'h3ff, 16'hffff, 16'hffff, 16'hffff);
        send(vna_pkg::KIND_QUERY, 10'd0, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_QUERY, 10'd1023, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_QUERY, 10'd682, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_QUERY, 10'd341, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_LOAD, 10'd0, 10'd0, 10'd0, 16'h1234, 16'hfedc, 16'h0001);
        send(vna_pkg::KIND_QUERY, 10'd0, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);

        // large sums: n = (+65535^2, 0, -65535^2) per triangle pushes x up and z down
        quiet = 1'b1;
        send(vna_pkg::KIND_LOAD, 10'd5, 10'd0, 10'd0, 16'h8000, 16'h8000, 16'h8000);
        send(vna_pkg::KIND_LOAD, 10'd6, 10'd0, 10'd0, 16'h8000, 16'h7fff, 16'h8000);
        send(vna_pkg::KIND_LOAD, 10'd7, 10'd0, 10'd0, 16'h7fff, 16'h8000, 16'h7fff);
        for (int i = 0; i < SAT_TRIS; i++)
        begin
            send(vna_pkg::KIND_TRI, 10'd5, 10'd6, 10'd7, 16'h0, 16'h0, 16'h0);
            if (i == SAT_TRIS / 2)
                send(vna_pkg::KIND_QUERY, 10'd6, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        end
        send(vna_pkg::KIND_QUERY, 10'd5, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_QUERY, 10'd6, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        send(vna_pkg::KIND_QUERY, 10'd7, 10'd0, 10'd0, 16'h0, 16'h0, 16'h0);
        quiet = 1'b0;
        items_sent = 0;

        // random: small working set of vertices so triangles share corners
        for (int i = 0; i < POOL_N; i++)
        begin
            pool[i] = 10'($urandom_range(0, 1023));
            send(vna_pkg::KIND_LOAD, pool[i], 10'($urandom_range(0, 1023)),
                 10'($urandom_range(0, 1023)), rand_pos(), rand_pos(), rand_pos());
        end
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == RAND_ITEMS / 2)
            begin
                // drain everything before going on
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            r = $urandom_range(0, 99);
            a = pool[$urandom_range(0, POOL_N - 1)];
            b = pool[$urandom_range(0, POOL_N - 1)];
            c = pool[$urandom_range(0, POOL_N - 1)];
            ra = 16'($urandom_range(0, 65535));
            rb = 16'($urandom_range(0, 65535));
            if (r < 14)
            begin
                r = $urandom_range(0, POOL_N - 1);
                if ($urandom_range(0, 1))
                    pool[r] = 10'($urandom_range(0, 1023));
                send(vna_pkg::KIND_LOAD, pool[r], b, c, rand_pos(), rand_pos(), rand_pos());
            end
            else if (r < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                    c = a;
                send(vna_pkg::KIND_TRI, a, b, c, ra, rb, rand_pos());
            end
            else if (r < 97)
                send(vna_pkg::KIND_QUERY, a, b, c, ra, rb, rand_pos());
            else
                send(vna_pkg::KIND_NONE, 10'($urandom_range(0, 1023)), b, c, ra, rb,
                     rand_pos());
        end
        s_tvalid <= 1'b0;

        // drain and settle
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
